// ----- hw/rtl/pat_pkg.sv -----
// pat_pkg: shared constants, codes and cell control types for the positional array table
// no dependencies; imported by the interfaces, the cell, the top level and the checker
package pat_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int KIND_W = 3;
  localparam int POS_W = 6;
  localparam int ST_W = 2;

  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FIND   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

  // what every cell does with its slot on one edge
  typedef enum logic [2:0] {
    CO_HOLD,
    CO_WRITE,
    CO_INSERT,
    CO_PAD,
    CO_DELETE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   pos;
    logic [CNT_W-1:0]   cnt;
    logic [KEY_W-1:0]   key;
  } cell_cmd_t;

  // read and search request, broadcast along the row
  typedef struct packed {
    logic [IDX_W-1:0]   pos;
    logic [CNT_W-1:0]   cnt;
    logic [KEY_W-1:0]   key;
  } cell_rd_t;

endpackage

// ----- hw/rtl/pat_in_if.sv -----
// pat_in_if: operation channel, valid/ready with kind, position and key
// depends on pat_pkg
interface pat_in_if import pat_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [POS_W-1:0]         position;
  logic signed [KEY_W-1:0]  key;

  modport source (output valid, kind, position, key, input ready);
  modport sink   (input valid, kind, position, key, output ready);
endinterface

// ----- hw/rtl/pat_out_if.sv -----
// pat_out_if: result channel, valid/ready with value, match index, flag, status and count
// depends on pat_pkg
interface pat_out_if import pat_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [KEY_W-1:0]  value;
  logic [POS_W-1:0]         match_index;
  logic                     found;
  logic [ST_W-1:0]          status;
  logic [CNT_W-1:0]         count;

  modport source (output valid, value, match_index, found, status, count, input ready);
  modport sink   (input valid, value, match_index, found, status, count, output ready);
endinterface

// ----- hw/rtl/pat_cell.sv -----
// pat_cell: one slot of the table, shifts with its neighbours and answers reads and searches
// depends on pat_pkg
module pat_cell import pat_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_cmd_t        cmd,
  input  cell_rd_t         rd,
  input  logic [KEY_W-1:0] left_entry,
  input  logic [KEY_W-1:0] right_entry,
  output logic [KEY_W-1:0] entry,
  output logic [KEY_W-1:0] rd_data,
  output logic             hit
);

  logic [KEY_W-1:0] entry_r;
  logic [KEY_W-1:0] entry_nxt;
  logic [CNT_W-1:0] idx_c;

  assign idx_c = CNT_W'(idx);

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      CO_WRITE: begin
        if (idx == cmd.pos) entry_nxt = cmd.key;
      end
      CO_INSERT: begin
        if (idx == cmd.pos) entry_nxt = cmd.key;
        else if (idx > cmd.pos) entry_nxt = left_entry;
      end
      CO_PAD: begin
        // gap between the old end and the new key fills with zeros
        if (idx == cmd.pos) entry_nxt = cmd.key;
        else if (idx_c >= cmd.cnt && idx < cmd.pos) entry_nxt = '0;
      end
      CO_DELETE: begin
        if (idx >= cmd.pos) entry_nxt = right_entry;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry   = entry_r;
  assign rd_data = (idx == rd.pos) ? entry_r : '0;
  assign hit     = (idx_c < rd.cnt) && (entry_r == rd.key);

endmodule

// ----- hw/rtl/positional_array_table_top.sv -----
// positional_array_table_top: bounded ordered key table built as a row of shifting cells
// depends on pat_pkg, pat_in_if, pat_out_if and pat_cell
//
// The table holds up to DEPTH (64) signed 32-bit keys in a row of cells, one key per
// cell, plus an entry count. Each beat on in_ch is one operation: append, insert at a
// position (higher entries move up; a position past the end pads the gap with zeros),
// set, delete at a position (higher entries move down), get, or find (first index
// holding the key). Every operation returns exactly one beat on out_ch carrying the
// read value, the match index, the found flag, a status code and the count after the
// operation. An item goes through two steps: on the accepting edge all cells shift or
// write at once and the operation enters the second step; there the get read (an OR of
// the one selected cell) and the find search (a priority encode over the per-cell
// compare flags) are formed and loaded into the output register. The two steps
// overlap, so with out_ch.ready held high a new operation is taken every cycle; a
// stalled result holds one operation in the second step and in_ch.ready drops until
// the result moves on. Slots are not cleared at reset; only the count and valid flags are.
module positional_array_table_top import pat_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pat_in_if.sink     in_ch,
  pat_out_if.source  out_ch
);

  // ---------------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // second step: operation waiting for its read or search
  logic               pend_r;
  logic [KIND_W-1:0]  pend_kind_r;
  logic [IDX_W-1:0]   pend_pos_r;
  logic [KEY_W-1:0]   pend_key_r;
  logic [ST_W-1:0]    pend_st_r;

  // output register
  logic               out_valid_r;
  logic [KEY_W-1:0]   out_value_r;
  logic [POS_W-1:0]   out_match_r;
  logic               out_found_r;
  logic [ST_W-1:0]    out_st_r;
  logic [CNT_W-1:0]   out_cnt_r;

  logic               in_fire;
  logic               move;
  logic               full;
  logic [CNT_W-1:0]   pos_c;
  logic [ST_W-1:0]    st_acc;
  cell_cmd_t          cmd;
  cell_rd_t           rd;

  // result of the second step
  logic [KEY_W-1:0]   rd_value;
  logic [IDX_W-1:0]   match_idx;
  logic               any_hit;
  logic [KEY_W-1:0]   res_value;
  logic [ST_W-1:0]    res_st;

  assign move    = pend_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !pend_r || move;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign pos_c = CNT_W'(in_ch.position);

  // ---------------------------------------------------------------------------
  // decode: status, count update and the command broadcast to the cells
  // ---------------------------------------------------------------------------
  always_comb begin
    cnt_nxt = cnt_r;
    st_acc  = ST_OK;
    cmd.op  = CO_HOLD;
    cmd.pos = IDX_W'(in_ch.position);
    cmd.cnt = cnt_r;
    cmd.key = in_ch.key;
    if (in_fire) begin
      case (in_ch.kind)
        KIND_APPEND: begin
          if (full) begin
            st_acc = ST_FULL;
          end else begin
            cmd.op  = CO_WRITE;
            cmd.pos = cnt_r[IDX_W-1:0];
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        KIND_INSERT: begin
          if (pos_c <= cnt_r) begin
            if (full) begin
              st_acc = ST_FULL;
            end else begin
              cmd.op  = CO_INSERT;
              cnt_nxt = cnt_r + 1'b1;
            end
          end else if (32'(in_ch.position) >= DEPTH) begin
            st_acc = ST_RANGE;
          end else begin
            cmd.op  = CO_PAD;
            cnt_nxt = pos_c + 1'b1;
          end
        end
        KIND_SET: begin
          if (pos_c >= cnt_r) st_acc = ST_RANGE;
          else cmd.op = CO_WRITE;
        end
        KIND_DELETE: begin
          if (pos_c >= cnt_r) begin
            st_acc = ST_RANGE;
          end else begin
            cmd.op  = CO_DELETE;
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        KIND_GET: begin
          if (pos_c >= cnt_r) st_acc = ST_RANGE;
        end
        default: st_acc = ST_OK;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // row of cells, each linked to its neighbours for shifting
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] ent_w  [DEPTH];
  logic [KEY_W-1:0] rdat_w [DEPTH];
  logic [DEPTH-1:0] hit_w;

  assign rd.pos = pend_pos_r;
  assign rd.cnt = cnt_r;
  assign rd.key = pend_key_r;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0] left_w;
    logic [KEY_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = ent_w[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      // top slot keeps stale bits after a delete; it sits above the count
      assign right_w = ent_w[g];
    end else begin : g_inner_r
      assign right_w = ent_w[g+1];
    end

    pat_cell u_cell (
      .clk         (clk),
      .idx         (IDX_W'(g)),
      .cmd         (cmd),
      .rd          (rd),
      .left_entry  (left_w),
      .right_entry (right_w),
      .entry       (ent_w[g]),
      .rd_data     (rdat_w[g]),
      .hit         (hit_w[g])
    );
  end

  // ---------------------------------------------------------------------------
  // second step: read merge and first-match search
  // ---------------------------------------------------------------------------
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_value = rd_value | rdat_w[i];
    end
  end

  // lowest set flag wins
  always_comb begin
    match_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit_w[i]) match_idx = IDX_W'(i);
    end
  end

  assign any_hit = |hit_w;

  always_comb begin
    res_value = '0;
    res_st    = pend_st_r;
    case (pend_kind_r)
      KIND_GET: begin
        if (pend_st_r == ST_OK) res_value = rd_value;
      end
      KIND_FIND: begin
        res_st = any_hit ? ST_OK : ST_MISS;
      end
      default: res_st = pend_st_r;
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) pend_r <= 1'b1;
      else if (move) pend_r <= 1'b0;
      if (move) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_kind_r <= in_ch.kind;
      pend_pos_r  <= IDX_W'(in_ch.position);
      pend_key_r  <= in_ch.key;
      pend_st_r   <= st_acc;
    end
    if (move) begin
      out_value_r <= res_value;
      out_match_r <= (pend_kind_r == KIND_FIND && any_hit) ? POS_W'(match_idx) : '0;
      out_found_r <= (pend_kind_r == KIND_FIND) && any_hit;
      out_st_r    <= res_st;
      out_cnt_r   <= cnt_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.value       = out_value_r;
  assign out_ch.match_index = out_match_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.count       = out_cnt_r;

endmodule

// ----- hw/rtl/pat_checker.sv -----
// pat_checker: port-level checks on the result channel of the table, with its bind
// depends on pat_pkg and positional_array_table_top
module pat_checker import pat_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KEY_W-1:0]  out_value,
  input logic [POS_W-1:0]  out_match_index,
  input logic              out_found,
  input logic [ST_W-1:0]   out_status,
  input logic [CNT_W-1:0]  out_count
);

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status)
      && $stable(out_count) && $stable(out_match_index) && $stable(out_found))
    else $error("stalled result changed");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("found with bad status");

  a_miss_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_index == '0)
    else $error("match index without hit");

  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value == '0)
    else $error("value on failed operation");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CNT_W'(DEPTH))
    else $error("count above depth");

endmodule

bind positional_array_table_top pat_checker u_pat_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_value       (out_ch.value),
  .out_match_index (out_ch.match_index),
  .out_found       (out_ch.found),
  .out_status      (out_ch.status),
  .out_count       (out_ch.count)
);

// ----- tb/pat_result_checker.sv -----
// pat_result_checker: watches the operation and result channels, predicts each result beat
// from a shadow copy of the key table and compares it field by field
// depends on pat_pkg, pat_in_if and pat_out_if
module pat_result_checker import pat_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pat_in_if    op_mon,
  pat_out_if   res_mon,
  output int   failures,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [KEY_W-1:0] value;
    logic [POS_W-1:0]        match_index;
    logic                    found;
    logic [ST_W-1:0]         status;
    logic [CNT_W-1:0]        count;
  } table_result_t;

  logic signed [KEY_W-1:0] shadow_slots [DEPTH];
  int                      shadow_fill;
  table_result_t           due_results [$];
  int                      fail_tally;

  // one operation on the shadow table, returns the result it should produce
  function automatic table_result_t table_apply(input logic [KIND_W-1:0] kind,
                                                input logic [POS_W-1:0] pos,
                                                input logic signed [KEY_W-1:0] key);
    table_result_t r;
    int            p;
    int            i;
    r = '0;
    r.status = ST_OK;
    p = int'(pos);
    case (kind)
      KIND_APPEND: begin
        if (shadow_fill >= DEPTH) r.status = ST_FULL;
        else begin
          shadow_slots[shadow_fill] = key;
          shadow_fill++;
        end
      end
      KIND_INSERT: begin
        if (p <= shadow_fill) begin
          if (shadow_fill >= DEPTH) r.status = ST_FULL;
          else begin
            for (i = shadow_fill; i > p; i--) shadow_slots[i] = shadow_slots[i-1];
            shadow_slots[p] = key;
            shadow_fill++;
          end
        end else if (p >= DEPTH) begin
          r.status = ST_RANGE;
        end else begin
          // gap past the end is padded with zeros
          for (i = shadow_fill; i < p; i++) shadow_slots[i] = '0;
          shadow_slots[p] = key;
          shadow_fill = p + 1;
        end
      end
      KIND_SET: begin
        if (p >= shadow_fill) r.status = ST_RANGE;
        else shadow_slots[p] = key;
      end
      KIND_DELETE: begin
        if (p >= shadow_fill) r.status = ST_RANGE;
        else begin
          for (i = p; i + 1 < shadow_fill; i++) shadow_slots[i] = shadow_slots[i+1];
          shadow_fill--;
        end
      end
      KIND_GET: begin
        if (p >= shadow_fill) r.status = ST_RANGE;
        else r.value = shadow_slots[p];
      end
      KIND_FIND: begin
        r.status = ST_MISS;
        for (i = 0; i < shadow_fill; i++) begin
          if (shadow_slots[i] == key) begin
            r.match_index = POS_W'(i);
            r.found = 1'b1;
            r.status = ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(shadow_fill);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [KEY_W-1:0] want,
                                      input logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
      fail_tally++;
    end
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      shadow_fill = 0;
      fail_tally = 0;
      due_results.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none got status %0d count %0d",
                   $time, res_mon.status, res_mon.count);
          fail_tally++;
        end else begin
          want = due_results.pop_front();
          check_field("value", want.value, res_mon.value);
          check_field("match_index", KEY_W'(want.match_index), KEY_W'(res_mon.match_index));
          check_field("found", KEY_W'(want.found), KEY_W'(res_mon.found));
          check_field("status", KEY_W'(want.status), KEY_W'(res_mon.status));
          check_field("count", KEY_W'(want.count), KEY_W'(res_mon.count));
        end
      end
      if (op_mon.valid && op_mon.ready)
        due_results.push_back(table_apply(op_mon.kind, op_mon.position, op_mon.key));
    end
    failures <= fail_tally;
    pending  <= due_results.size();
  end

endmodule

// ----- tb/testbench.sv -----
// testbench: drives operation beats into the positional array table and gives the verdict
// depends on pat_pkg, pat_in_if, pat_out_if, positional_array_table_top and pat_result_checker
module testbench;
  import pat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // kinds the block ignores, outside the operation set
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  localparam int RANDOM_OPS  = 1000;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_LEN   = 80;    // ops per grow or shrink phase

  logic clk;
  logic rst_n;
  int   failures;
  int   pending;
  int   cycles;
  int   fill_guess;   // rough entry count, only used to aim positions

  pat_in_if  in_ch ();
  pat_out_if out_ch ();

  positional_array_table_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pat_result_checker i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_mon   (in_ch),
    .res_mon  (out_ch),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // present one beat and hold it until the block takes it
  task automatic send_op(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                         input logic signed [KEY_W-1:0] v);
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= k;
    in_ch.position <= p;
    in_ch.key      <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // keep the count estimate in step so positions land near the live end
    case (k)
      KIND_APPEND: if (fill_guess < DEPTH) fill_guess++;
      KIND_INSERT: begin
        if (int'(p) <= fill_guess) begin
          if (fill_guess < DEPTH) fill_guess++;
        end else begin
          fill_guess = int'(p) + 1;
        end
      end
      KIND_DELETE: if (int'(p) < fill_guess) fill_guess--;
      default: ;
    endcase
  endtask

  // mostly keys from a small pool so finds hit and duplicates appear
  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] pool [8];
    pool = '{32'sd0, -32'sd1, 32'sd1, 32'h8000_0000, 32'h7fff_ffff, 32'sd42,
             32'sd1000, -32'sd1000};
    if ($urandom_range(0, 9) < 6) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // position near the live part of the table, now and then anywhere
  function automatic logic [POS_W-1:0] pick_pos();
    int top;
    top = (fill_guess > DEPTH - 1) ? DEPTH - 1 : fill_guess;
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, DEPTH - 1));
    return POS_W'($urandom_range(0, top));
  endfunction

  // receiver: stall patterns of its own, with long hold-offs so the row backs up
  initial begin
    int seg;
    int len;
    int mode;
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    seg = 0;
    forever begin
      if (seg == 4 || seg == 15) begin
        // long hold-off while the sender keeps offering beats
        for (n = 0; n < 300; n++) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(20, 120);
        for (n = 0; n < len; n++) begin
          case (mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
      seg++;
    end
  end

  // sender: directed corner cases, then random bursts with gaps
  initial begin
    int  real_ops;
    int  burst;
    int  gap;
    int  r;
    int  b;
    bit  grow;
    logic [KIND_W-1:0] k;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= KIND_APPEND;
    in_ch.position <= '0;
    in_ch.key      <= '0;
    fill_guess      = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: every positional access is out of range, find misses
    send_op(KIND_GET,    6'd0, 32'sd0);
    send_op(KIND_FIND,   6'd0, 32'sd5);
    send_op(KIND_DELETE, 6'd0, 32'sd0);
    send_op(KIND_SET,    6'd0, 32'sd9);
    // key extremes
    send_op(KIND_APPEND, 6'd0, 32'h8000_0000);
    send_op(KIND_APPEND, 6'd0, 32'h7fff_ffff);
    send_op(KIND_APPEND, 6'd0, 32'sd0);
    send_op(KIND_APPEND, 6'd0, -32'sd1);
    // insert at front, middle, at the end and past the end (zero padding)
    send_op(KIND_INSERT, 6'd0,  32'sd123);
    send_op(KIND_INSERT, 6'd2,  -32'sd77);
    send_op(KIND_INSERT, 6'd6,  32'sd55);
    send_op(KIND_INSERT, 6'd12, 32'sd99);
    send_op(KIND_GET,    6'd9,  32'sd0);
    send_op(KIND_FIND,   6'd0,  32'h7fff_ffff);
    send_op(KIND_FIND,   6'd0,  32'sd0);
    send_op(KIND_SET,    6'd3,  32'ha5a5_a5a5);
    send_op(KIND_DELETE, 6'd0,  32'sd0);
    send_op(KIND_DELETE, 6'd11, 32'sd0);
    // ignored kinds
    send_op(KIND_SPARE_LO, 6'd63, 32'sd7);
    send_op(KIND_SPARE_HI, 6'd1,  -32'sd7);
    // pad straight to the top slot: table full
    send_op(KIND_INSERT, 6'd63, 32'sd42);
    send_op(KIND_APPEND, 6'd0,  32'sd1);
    send_op(KIND_INSERT, 6'd10, 32'sd2);
    send_op(KIND_INSERT, 6'd63, 32'sd3);
    send_op(KIND_GET,    6'd63, 32'sd0);
    send_op(KIND_DELETE, 6'd63, 32'sd0);
    send_op(KIND_FIND,   6'd0,  32'sd12345);
    send_op(KIND_GET,    6'd63, 32'sd0);

    // random part: alternating grow and shrink phases sweep the count end to end
    real_ops = 0;
    while (real_ops < RANDOM_OPS) begin
      burst = $urandom_range(1, 24);
      for (b = 0; b < burst && real_ops < RANDOM_OPS; b++) begin
        grow = ((real_ops / PHASE_LEN) % 2) == 0;
        r = $urandom_range(0, 99);
        if (grow) begin
          if      (r < 30) k = KIND_APPEND;
          else if (r < 50) k = KIND_INSERT;
          else if (r < 58) k = KIND_SET;
          else if (r < 65) k = KIND_DELETE;
          else if (r < 80) k = KIND_GET;
          else if (r < 96) k = KIND_FIND;
          else             k = $urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI;
        end else begin
          if      (r < 8)  k = KIND_APPEND;
          else if (r < 16) k = KIND_INSERT;
          else if (r < 26) k = KIND_SET;
          else if (r < 60) k = KIND_DELETE;
          else if (r < 75) k = KIND_GET;
          else if (r < 96) k = KIND_FIND;
          else             k = $urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI;
        end
        send_op(k, pick_pos(), pick_key());
        // ignored kinds do not count as work
        if (k != KIND_SPARE_LO && k != KIND_SPARE_HI) real_ops++;
      end
      // gap between bursts, often none so long back-to-back runs occur
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    // let the checker register the last beat, drain, then wait for any stray beat
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pat_pkg.sv
hw/rtl/pat_in_if.sv
hw/rtl/pat_out_if.sv
hw/rtl/pat_cell.sv
hw/rtl/positional_array_table_top.sv
hw/rtl/pat_checker.sv
tb/pat_result_checker.sv
tb/testbench.sv
